>>> design/hts_pkg.sv
package hts_pkg;

	// default geometry
	localparam int GRID_SIDE_DEF = 512;
	localparam int FRAC_BITS_DEF = 20;

	// fixed field widths
	localparam int COORD_W  = 16;
	localparam int LOAD_W   = 9;
	localparam int SAMPLE_W = 16;
	localparam int INV_W    = 21;
	localparam int MAXH_W   = 8;
	localparam int HEIGHT_W = 24;
	localparam int NORMAL_W = 25;
	localparam int HSUM_W   = 27;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 21;
	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 80;

	// divide by five: multiply by ceil(2^34 / 5), exact for 32-bit operands
	localparam logic [31:0] RECIP5 = 32'hCCCC_CCCD;
	localparam int RECIP5_SH = 34;

	// register reset values
	localparam logic [INV_W-1:0]  INV_RESET  = 21'd523264;
	localparam logic [MAXH_W-1:0] MAXH_RESET = 8'd100;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ORIGIN_X   = 3'd0,
		REG_ORIGIN_Z   = 3'd1,
		REG_INV_CELL   = 3'd2,
		REG_MAX_HEIGHT = 3'd3,
		REG_SMOOTH     = 3'd4
	} reg_idx_t;

	// controller to datapath
	typedef struct packed {
		logic       store;
		logic       capture;
		logic       locate;
		logic       rd;
		logic       nbr;
		logic       scale;
		logic       mac;
		logic       nacc;
		logic       tap_end;
		logic       div;
		logic       out_load;
		logic [2:0] tap;
		logic [1:0] sel;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic tap_inr;
		logic centre_inr;
		logic smooth;
		logic out_free;
	} status_t;

endpackage

>>> design/heightfield_triangle_sampler_core.sv
// Height field sampler. Load items (tuser 0) write one 16-bit sample into a
// GRID_SIDE x GRID_SIDE single-port store. Query items (tuser 1) map a world
// position to a grid cell, interpolate the height over the cell triangle that
// holds it, and return height, an in-range flag and the x/z corner normal.
// Every corner and neighbor read goes through the one store port with an
// address, a scale and an accumulate step. A query runs one tap, or five
// taps with smoothing, then four neighbor reads while the centre is in
// range, a divide and the output. A finished result waits in an output
// register while the next item is accepted. Entries must be loaded before a
// query reads them; the store has no reset.
module heightfield_triangle_sampler_core #(
	parameter int GRID_SIDE = hts_pkg::GRID_SIDE_DEF,
	parameter int FRAC_BITS = hts_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hts_pkg::CFG_DAT_W-1:0]  cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// load_x, load_z, sample, world_x, world_z, zero pad
	input  logic [hts_pkg::IN_DATA_W-1:0]  s_tdata,
	// req_type
	input  logic                           s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// height_q16, normal_x, normal_z, zero pad
	output logic [hts_pkg::OUT_DATA_W-1:0] m_tdata,
	// in_range
	output logic                           m_tuser
);
	import hts_pkg::*;

	cmd_t    cmd;
	status_t st;

	hts_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tuser (s_tuser),
		.st      (st),
		.cmd     (cmd)
	);

	hts_datapath #(
		.GRID_SIDE(GRID_SIDE),
		.FRAC_BITS(FRAC_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.st       (st),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

>>> design/hts_ram.sv
module hts_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> design/hts_datapath.sv
module hts_datapath #(
	parameter int GRID_SIDE = hts_pkg::GRID_SIDE_DEF,
	parameter int FRAC_BITS = hts_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  hts_pkg::cmd_t                  cmd,
	output hts_pkg::status_t               st,
	input  logic                           cfg_we,
	input  logic [hts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [hts_pkg::CFG_DAT_W-1:0]  cfg_wdata,
	input  logic [hts_pkg::IN_DATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [hts_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic                           m_tuser
);
	import hts_pkg::*;

	localparam int CW    = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
	localparam int DEPTH = GRID_SIDE * GRID_SIDE;
	localparam int AW    = $clog2(DEPTH);
	localparam int PW    = 40;
	localparam int CLW   = PW - FRAC_BITS;
	localparam int WW    = FRAC_BITS + 1;
	localparam int ACCW  = WW + HEIGHT_W + 2;
	localparam logic [WW-1:0]   ONE   = WW'(1) << FRAC_BITS;
	localparam logic [ACCW-1:0] HALF  = ACCW'(1) << (FRAC_BITS - 1);
	localparam logic [CLW-1:0]  CLIM  = CLW'(GRID_SIDE - 1);
	localparam logic [10:0]     GLIM  = 11'(GRID_SIDE);

	// configuration registers
	logic signed [COORD_W-1:0] origin_x_q, origin_z_q;
	logic [INV_W-1:0]          inv_q;
	logic [MAXH_W-1:0]         maxh_q;
	logic                      smooth_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_z_q <= '0;
			inv_q      <= INV_RESET;
			maxh_q     <= MAXH_RESET;
			smooth_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ORIGIN_X:   origin_x_q <= cfg_wdata[COORD_W-1:0];
				REG_ORIGIN_Z:   origin_z_q <= cfg_wdata[COORD_W-1:0];
				REG_INV_CELL:   inv_q      <= cfg_wdata[INV_W-1:0];
				REG_MAX_HEIGHT: maxh_q     <= cfg_wdata[MAXH_W-1:0];
				REG_SMOOTH:     smooth_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// input fields
	logic [LOAD_W-1:0]   load_x, load_z;
	logic [SAMPLE_W-1:0] sample;
	logic signed [COORD_W-1:0] world_x, world_z;
	assign load_x  = s_tdata[8:0];
	assign load_z  = s_tdata[17:9];
	assign sample  = s_tdata[33:18];
	assign world_x = s_tdata[49:34];
	assign world_z = s_tdata[65:50];

	logic load_ok;
	assign load_ok = (11'(load_x) < GLIM) && (11'(load_z) < GLIM);

	// query position
	logic signed [COORD_W-1:0] wx_q, wz_q;
	logic signed [17:0] dx, dz, posx, posz;
	logic signed [PW-1:0] px, pz;
	logic inr_x, inr_z;

	always_comb begin
		dx = '0;
		dz = '0;
		unique case (cmd.tap)
			3'd1: dx = 18'sd1;
			3'd2: dx = -18'sd1;
			3'd3: dz = 18'sd1;
			3'd4: dz = -18'sd1;
			default: ;
		endcase
	end

	assign posx = 18'(wx_q) + dx - 18'(origin_x_q);
	assign posz = 18'(wz_q) + dz - 18'(origin_z_q);
	assign px = posx * $signed({1'b0, inv_q});
	assign pz = posz * $signed({1'b0, inv_q});
	assign inr_x = !px[PW-1] && (px[PW-1:FRAC_BITS] < CLIM);
	assign inr_z = !pz[PW-1] && (pz[PW-1:FRAC_BITS] < CLIM);

	// located cell of the current tap
	logic [CW-1:0]        gx_q, gz_q, cx_q, cz_q;
	logic [FRAC_BITS-1:0] fx_q, fz_q;
	logic                 tinr_q, cinr_q;

	// triangle selection and weights
	logic [WW:0]   fsum;
	logic          lower;
	logic [WW-1:0] w;
	assign fsum  = (WW+1)'(fx_q) + (WW+1)'(fz_q);
	assign lower = fsum <= (WW+1)'(ONE);

	always_comb begin
		unique case (cmd.sel)
			2'd0: w = lower ? WW'((WW+1)'(ONE) - fsum) : ONE - WW'(fz_q);
			2'd1: w = lower ? WW'(fx_q) : WW'(fsum - (WW+1)'(ONE));
			2'd2: w = lower ? WW'(fz_q) : ONE - WW'(fx_q);
			default: w = '0;
		endcase
	end

	// corner or neighbor coordinate for a read
	logic [CW-1:0]    bx, bz;
	logic signed [1:0] ox, oz;
	logic signed [CW+1:0] rx, rz;
	logic             rvalid;

	always_comb begin
		bx = cmd.nbr ? cx_q : gx_q;
		bz = cmd.nbr ? cz_q : gz_q;
		ox = '0;
		oz = '0;
		if (cmd.nbr) begin
			unique case (cmd.sel)
				2'd0: ox = -2'sd1;
				2'd1: ox = 2'sd1;
				2'd2: oz = -2'sd1;
				2'd3: oz = 2'sd1;
			endcase
		end else begin
			unique case (cmd.sel)
				2'd0: ox = lower ? 2'sd0 : 2'sd1;
				2'd1: begin
					ox = 2'sd1;
					oz = lower ? 2'sd0 : 2'sd1;
				end
				2'd2: oz = 2'sd1;
				default: ;
			endcase
		end
		rx = $signed({2'b00, bx}) + (CW+2)'(ox);
		rz = $signed({2'b00, bz}) + (CW+2)'(oz);
		rvalid = !rx[CW+1] && !rz[CW+1] && (rx < $signed((CW+2)'(GRID_SIDE)))
			&& (rz < $signed((CW+2)'(GRID_SIDE)));
	end

	// height store
	logic [AW-1:0]       ram_addr;
	logic [SAMPLE_W-1:0] ram_rdata;
	logic                ram_we;

	assign ram_we   = cmd.store && load_ok;
	assign ram_addr = cmd.rd
		? AW'(AW'(rz[CW-1:0]) * AW'(GRID_SIDE) + AW'(rx[CW-1:0]))
		: AW'(AW'(load_z) * AW'(GRID_SIDE) + AW'(load_x));

	hts_ram #(
		.WIDTH(SAMPLE_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(sample),
		.rdata(ram_rdata)
	);

	// arithmetic registers
	logic                       vld_q;
	logic [HEIGHT_W-1:0]        h_q;
	logic [ACCW-1:0]            acc_q;
	logic [ACCW-1:0]            acc_rnd;
	logic [HSUM_W-1:0]          hsum_q;
	logic signed [NORMAL_W-1:0] nx_q, nz_q;
	logic [63:0]                prod_q;

	assign acc_rnd = acc_q + HALF;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			wx_q   <= world_x;
			wz_q   <= world_z;
			acc_q  <= '0;
			hsum_q <= '0;
			nx_q   <= '0;
			nz_q   <= '0;
		end
		if (cmd.locate) begin
			tinr_q <= inr_x && inr_z;
			gx_q   <= px[FRAC_BITS+CW-1:FRAC_BITS];
			gz_q   <= pz[FRAC_BITS+CW-1:FRAC_BITS];
			fx_q   <= px[FRAC_BITS-1:0];
			fz_q   <= pz[FRAC_BITS-1:0];
		end
		if (cmd.rd) begin
			vld_q <= rvalid;
		end
		if (cmd.scale) begin
			h_q <= vld_q ? HEIGHT_W'(ram_rdata) * HEIGHT_W'(maxh_q) : '0;
		end
		if (cmd.mac) begin
			acc_q <= acc_q + ACCW'(w) * ACCW'(h_q);
		end
		// neighbor differences
		if (cmd.nacc) begin
			unique case (cmd.sel)
				2'd0: nx_q <= nx_q + $signed({1'b0, h_q});
				2'd1: nx_q <= nx_q - $signed({1'b0, h_q});
				2'd2: nz_q <= nz_q + $signed({1'b0, h_q});
				2'd3: nz_q <= nz_q - $signed({1'b0, h_q});
			endcase
		end
		// close one tap
		if (cmd.tap_end) begin
			if (tinr_q) begin
				hsum_q <= hsum_q + HSUM_W'(acc_rnd[FRAC_BITS+HEIGHT_W-1:FRAC_BITS]);
			end
			acc_q <= '0;
			if (cmd.tap == 3'd0) begin
				cinr_q <= tinr_q;
				cx_q   <= gx_q;
				cz_q   <= gz_q;
			end
		end
		if (cmd.div) begin
			prod_q <= 64'(32'(hsum_q) + 32'd2) * 64'(RECIP5);
		end
	end

	// result register
	logic                      ov_q;
	logic [OUT_DATA_W-1:0]     od_q;
	logic                      ou_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.out_load) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			od_q <= {6'd0, nz_q, nx_q,
				smooth_q ? prod_q[RECIP5_SH+HEIGHT_W-1:RECIP5_SH] : hsum_q[HEIGHT_W-1:0]};
			ou_q <= cinr_q;
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = od_q;
	assign m_tuser  = ou_q;

	assign st.tap_inr    = tinr_q;
	assign st.centre_inr = cinr_q;
	assign st.smooth     = smooth_q;
	assign st.out_free   = !ov_q || m_tready;

endmodule

>>> design/hts_ctrl.sv
module hts_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic             s_tuser,
	input  hts_pkg::status_t st,
	output hts_pkg::cmd_t    cmd
);
	import hts_pkg::*;

	typedef enum logic [3:0] {
		IDLE, LOC, RD, SC, MAC, TEND, NRD, NSC, NACC, DIV, FIN
	} state_t;

	state_t     state_q;
	logic [2:0] tap_q;
	logic [1:0] sel_q;

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			tap_q   <= '0;
			sel_q   <= '0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (s_tvalid && s_tuser) begin
						tap_q   <= '0;
						state_q <= LOC;
					end
				end
				LOC: begin
					sel_q   <= '0;
					state_q <= RD;
				end
				RD: state_q <= st.tap_inr ? SC : TEND;
				SC: state_q <= MAC;
				MAC: begin
					if (sel_q == 2'd2) begin
						state_q <= TEND;
					end else begin
						sel_q   <= sel_q + 2'd1;
						state_q <= RD;
					end
				end
				TEND: begin
					if (st.smooth && tap_q != 3'd4) begin
						tap_q   <= tap_q + 3'd1;
						state_q <= LOC;
					end else begin
						sel_q   <= '0;
						state_q <= NRD;
					end
				end
				NRD: state_q <= st.centre_inr ? NSC : DIV;
				NSC: state_q <= NACC;
				NACC: begin
					if (sel_q == 2'd3) begin
						state_q <= DIV;
					end else begin
						sel_q   <= sel_q + 2'd1;
						state_q <= NRD;
					end
				end
				DIV: state_q <= FIN;
				FIN: begin
					if (st.out_free) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign s_tready = (state_q == IDLE);

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.tap      = tap_q;
		cmd.sel      = sel_q;
		cmd.store    = (state_q == IDLE) && s_tvalid && !s_tuser;
		cmd.capture  = (state_q == IDLE) && s_tvalid && s_tuser;
		cmd.locate   = (state_q == LOC);
		cmd.rd       = ((state_q == RD) && st.tap_inr) || ((state_q == NRD) && st.centre_inr);
		cmd.nbr      = (state_q == NRD) || (state_q == NSC) || (state_q == NACC);
		cmd.scale    = (state_q == SC) || (state_q == NSC);
		cmd.mac      = (state_q == MAC);
		cmd.nacc     = (state_q == NACC);
		cmd.tap_end  = (state_q == TEND);
		cmd.div      = (state_q == DIV);
		cmd.out_load = (state_q == FIN) && st.out_free;
	end

endmodule

>>> design/hts_checker.sv
module hts_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           s_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [hts_pkg::OUT_DATA_W-1:0] m_tdata,
	input logic                           m_tuser
);

	// a stalled result stays
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// an accepted query keeps the input closed next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser |=> !s_tready)
		else $error("input reopened right after a query");

	// out-of-range results carry zero normals
	a_zero_normal: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[73:24] == 50'd0)
		else $error("normal nonzero outside the grid");

	// pad bits are zero
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[79:74] == 6'd0)
		else $error("pad bits set");

endmodule

bind heightfield_triangle_sampler_core hts_checker u_chk (.*);
